// ----- src/mks_pkg.sv -----
package mks_pkg;

    // Configuration register map
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE  = 1'd1;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [15:0] RELEASE_RESET  = 16'd50;

    // Fixed 4x4 keypad legend, row-major
    localparam logic [7:0] KEY_MAP [16] = '{
        8'h37, 8'h38, 8'h39, 8'h2F,   // 7 8 9 /
        8'h34, 8'h35, 8'h36, 8'h2A,   // 4 5 6 *
        8'h31, 8'h32, 8'h33, 8'h2D,   // 1 2 3 -
        8'h43, 8'h30, 8'h3D, 8'h2B    // C 0 = +
    };

    // One result item as it leaves the scanner core
    typedef struct packed {
        logic [3:0] row_drive;
        logic       key_valid;
        logic [7:0] key_code;
        logic [3:0] key_position;
    } mks_result_t;

    function automatic logic [7:0] key_char(input logic [1:0] row, input logic [1:0] col);
        return KEY_MAP[{row, col}];
    endfunction

endpackage

// ----- src/mks_core.sv -----
module mks_core #(
    parameter int ROWS = 4,
    parameter int COLS = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [mks_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [mks_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           item_accept,
    input  logic [3:0]                     column_lines,
    output mks_pkg::mks_result_t           result_next
);
    import mks_pkg::*;

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam int RCW = $clog2(COLS + 1);
    localparam int LW = (COLS > 4) ? COLS : 4;

    typedef enum logic [1:0] {
        PH_SCAN,
        PH_DEBOUNCE,
        PH_RELEASE,
        PH_HOLDOFF
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [RCW-1:0]  resume_reg, resume_next;
    logic [CW-1:0]   cand_reg, cand_next;
    logic [15:0]     wait_reg, wait_next;
    logic [15:0]     debounce_reg;
    logic [15:0]     release_reg;

    logic [LW-1:0]   press_ext;
    logic [COLS-1:0] pressed;
    logic [COLS-1:0] scan_mask;
    logic [COLS-1:0] scan_hits;
    logic            scan_found;
    logic [CW-1:0]   scan_col;
    logic            cand_low;
    logic [RW-1:0]   row_inc;
    logic            report;
    logic [7:0]      row_bit;
    logic [7:0]      pos_full;

    // Columns beyond the four physical lines read as released
    assign press_ext = LW'(~column_lines);
    assign pressed   = press_ext[COLS-1:0];
    assign cand_low  = pressed[cand_reg];

    // Lowest pressed column at or after the resume point
    assign scan_mask = {COLS{1'b1}} << resume_reg;
    assign scan_hits = pressed & scan_mask;
    assign scan_found = |scan_hits;
    always_comb begin
        scan_col = '0;
        for (int c = COLS - 1; c >= 0; c--) begin
            if (scan_hits[c]) begin
                scan_col = CW'(c);
            end
        end
    end

    assign row_inc = (row_reg == RW'(ROWS - 1)) ? '0 : row_reg + 1'b1;

    // Next-state logic for one tick
    always_comb begin
        phase_next  = phase_reg;
        row_next    = row_reg;
        resume_next = resume_reg;
        cand_next   = cand_reg;
        wait_next   = wait_reg;
        report      = 1'b0;
        case (phase_reg)
            PH_SCAN: begin
                if (scan_found) begin
                    cand_next  = scan_col;
                    wait_next  = debounce_reg;
                    phase_next = PH_DEBOUNCE;
                end else begin
                    row_next    = row_inc;
                    resume_next = '0;
                end
            end
            PH_DEBOUNCE: begin
                if (wait_reg != '0) begin
                    wait_next = wait_reg - 1'b1;
                end else if (cand_low) begin
                    phase_next = PH_RELEASE;
                end else begin
                    phase_next = PH_SCAN;
                    if (cand_reg == CW'(COLS - 1)) begin
                        row_next    = row_inc;
                        resume_next = '0;
                    end else begin
                        resume_next = RCW'(cand_reg) + 1'b1;
                    end
                end
            end
            PH_RELEASE: begin
                if (!cand_low) begin
                    wait_next  = release_reg;
                    phase_next = PH_HOLDOFF;
                end
            end
            PH_HOLDOFF: begin
                if (wait_reg != '0) begin
                    wait_next = wait_reg - 1'b1;
                end else begin
                    report      = 1'b1;
                    phase_next  = PH_SCAN;
                    row_next    = '0;
                    resume_next = '0;
                end
            end
            default: begin
                phase_next = PH_SCAN;
            end
        endcase
    end

    // Result item: row drive follows the updated row, key fields the old one
    assign row_bit  = 8'(1) << row_next;
    assign pos_full = 8'(row_reg) * 8'(COLS) + 8'(cand_reg);

    always_comb begin
        result_next.row_drive    = ~row_bit[3:0];
        result_next.key_valid    = report;
        result_next.key_code     = '0;
        result_next.key_position = '0;
        if (report) begin
            result_next.key_position = pos_full[3:0];
            if ((4'(row_reg) < 4'd4) && (4'(cand_reg) < 4'd4)) begin
                result_next.key_code = key_char(2'(row_reg), 2'(cand_reg));
            end
        end
    end

    // Scan state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SCAN;
            row_reg      <= '0;
            resume_reg   <= '0;
            cand_reg     <= '0;
            wait_reg     <= '0;
            debounce_reg <= DEBOUNCE_RESET;
            release_reg  <= RELEASE_RESET;
        end else begin
            if (item_accept) begin
                phase_reg  <= phase_next;
                row_reg    <= row_next;
                resume_reg <= resume_next;
                cand_reg   <= cand_next;
                wait_reg   <= wait_next;
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_DEBOUNCE: debounce_reg <= cfg_wdata;
                    REG_RELEASE:  release_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- src/mks_out_reg.sv -----
module mks_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mks_pkg::mks_result_t in_result,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mks_pkg::mks_result_t out_result
);
    import mks_pkg::*;

    logic        valid_reg;
    mks_result_t result_reg;

    // Take a new item whenever the held one is gone or leaving now
    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            result_reg <= in_result;
        end
    end

endmodule

// ----- src/matrix_keypad_scanner.sv -----
// Matrix keypad scanner: each input item is one scan tick carrying the sampled
// column lines (active low), which answer the row drive of the previous result.
// Every accepted tick yields exactly one result item holding the new row drive
// and, on the tick a debounced and released key is confirmed, its keymap code
// and position with the valid flag set in tuser. One tick is accepted per clock
// cycle and its result appears in the next cycle: the result is computed
// combinationally and sits in one output register, which takes a new
// item in the same cycle the held one leaves, so the input stalls only while a
// result is held and not taken. Debounce and release hold-off times are counted
// in ticks and set through the config port (index 0 debounce, index 1 release);
// write them only while idle.
module matrix_keypad_scanner #(
    parameter int ROWS = 4,
    parameter int COLS = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration writes
    input  logic                           cfg_wr_en,
    input  logic [mks_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [mks_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Tick input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [3:0] column_lines, [7:4] zero
    // Result output
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,   // [3:0] row_drive, [11:4] key_code,
                                                           // [15:12] key_position
    output logic                           m_axis_tuser    // [0] key_valid
);
    import mks_pkg::*;

    mks_result_t result_next;
    mks_result_t result_q;
    logic        item_accept;

    assign item_accept = s_axis_tvalid && s_axis_tready;

    mks_core #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .item_accept  (item_accept),
        .column_lines (s_axis_tdata[3:0]),
        .result_next  (result_next)
    );

    mks_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_result  (result_next),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result_q)
    );

    // Pack the result item
    assign m_axis_tdata = {result_q.key_position, result_q.key_code, result_q.row_drive};
    assign m_axis_tuser = result_q.key_valid;

endmodule

// ----- sim/matrix_keypad_scanner_tb.sv -----
`timescale 1ns / 100ps

module matrix_keypad_scanner_tb;

    localparam int STALL_LIMIT     = 3000;  // cycles without any handshake
    localparam int PRESSURE_CYCLES = 400;   // long sink hold-off
    localparam int MAX_GAP         = 12;

    typedef enum logic [1:0] {
        SCANNING,
        DEBOUNCING,
        AWAIT_RELEASE,
        HOLDING_OFF
    } scan_phase_e;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [mks_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [mks_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'hFF;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    // Expected scanner behaviour plus the queue of results still to arrive
    class keypad_scoreboard;
        scan_phase_e phase;
        int          row;
        int          resume_col;
        int          cand_col;
        int unsigned countdown;
        int unsigned debounce_len;
        int unsigned release_len;
        int unsigned keys_reported;
        int unsigned results_seen;
        int unsigned errors;
        string       legend;
        mks_pkg::mks_result_t due_results[$];

        function new();
            legend        = "789/456*123-C0=+";
            phase         = SCANNING;
            row           = 0;
            resume_col    = 0;
            cand_col      = 0;
            countdown     = 0;
            debounce_len  = 20;
            release_len   = 50;
            keys_reported = 0;
            results_seen  = 0;
            errors        = 0;
        endfunction

        function void advance_row();
            row        = (row == 3) ? 0 : row + 1;
            resume_col = 0;
        endfunction

        // One accepted tick: step the scan state and queue the result it yields
        function void note_tick(logic [3:0] lines);
            mks_pkg::mks_result_t r;
            bit found;
            int c;
            r = '0;
            case (phase)
                SCANNING: begin
                    found = 1'b0;
                    for (c = 0; c < 4; c++) begin
                        if (!found && c >= resume_col && !lines[c]) begin
                            found    = 1'b1;
                            cand_col = c;
                        end
                    end
                    if (found) begin
                        countdown = debounce_len;
                        phase     = DEBOUNCING;
                    end else begin
                        advance_row();
                    end
                end
                DEBOUNCING: begin
                    if (countdown != 0) begin
                        countdown--;
                    end else if (!lines[cand_col]) begin
                        phase = AWAIT_RELEASE;
                    end else begin
                        // bounced: carry on from the next column
                        resume_col = cand_col + 1;
                        if (resume_col >= 4)
                            advance_row();
                        phase = SCANNING;
                    end
                end
                AWAIT_RELEASE: begin
                    if (lines[cand_col]) begin
                        countdown = release_len;
                        phase     = HOLDING_OFF;
                    end
                end
                HOLDING_OFF: begin
                    if (countdown != 0) begin
                        countdown--;
                    end else begin
                        r.key_valid    = 1'b1;
                        r.key_code     = legend[row * 4 + cand_col];
                        r.key_position = 4'(row * 4 + cand_col);
                        phase          = SCANNING;
                        row            = 0;
                        resume_col     = 0;
                        keys_reported++;
                    end
                end
                default: ;
            endcase
            r.row_drive = ~(4'b0001 << row);
            due_results.push_back(r);
        endfunction

        task report(input string msg);
            errors++;
            $display("mismatch at result %0d: %s", results_seen, msg);
        endtask

        task check_result(input logic [15:0] data, input logic flag);
            mks_pkg::mks_result_t want;
            results_seen++;
            if (due_results.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            want = due_results.pop_front();
            if (data[3:0] !== want.row_drive)
                report($sformatf("row_drive %h, expected %h", data[3:0], want.row_drive));
            if (flag !== want.key_valid)
                report($sformatf("key_valid %b, expected %b", flag, want.key_valid));
            if (data[11:4] !== want.key_code)
                report($sformatf("key_code %h, expected %h", data[11:4], want.key_code));
            if (data[15:12] !== want.key_position)
                report($sformatf("key_position %0d, expected %0d",
                                 data[15:12], want.key_position));
        endtask
    endclass

    keypad_scoreboard board;

    int unsigned ticks_sent  = 0;
    int          sink_gap    = 0;
    int          quiet_count = 0;
    bit          tx_idle     = 1'b1;
    logic        rx_idle     = 1'b1;
    logic        rx_blocked  = 1'b0;

    // Walks every row, hits each column as candidate, then two clean key presses
    logic [3:0] directed_cols [0:23] = '{
        4'hF, 4'hF, 4'hF, 4'hF,
        4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'hF, 4'h7, 4'hF,
        4'hE, 4'hE, 4'hE, 4'hF, 4'h0,
        4'hF, 4'hF, 4'hF, 4'h7, 4'h7, 4'hF, 4'hF
    };

    matrix_keypad_scanner dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Result sink: check each item, then draw the stall before the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            sink_gap = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_result(m_axis_tdata, m_axis_tuser);
                sink_gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            end else if (sink_gap > 0) begin
                sink_gap--;
            end
            m_axis_tready <= (sink_gap == 0) && !rx_blocked;
        end
    end

    // Watchdog: too long with neither side moving
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= STALL_LIMIT) begin
            $display("FAIL matrix_keypad_scanner");
            $finish;
        end
    end

    task automatic send_tick(input logic [3:0] lines);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, lines};
        do @(posedge aclk); while (!s_axis_tready);
        board.note_tick(lines);
        ticks_sent++;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_timing(input logic [15:0] deb, input logic [15:0] rel);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= mks_pkg::REG_DEBOUNCE;
        cfg_wdata <= deb;
        @(posedge aclk);
        cfg_addr  <= mks_pkg::REG_RELEASE;
        cfg_wdata <= rel;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.debounce_len = 32'(deb);
        board.release_len  = 32'(rel);
    endtask

    task automatic pick_idling();
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle <= ($urandom_range(0, 3) != 0);
    endtask

    // One press/release of the simulated keypad; the columns follow the row
    // the scanner is driving. A clean episode holds a single key long enough
    // to be reported and ends with the scanner back on row 0.
    task automatic key_episode(input bit clean);
        logic [15:0] held;
        logic [3:0]  lines;
        int unsigned press_len;
        int unsigned quiet_len;
        int unsigned deb;
        int unsigned rel;
        deb = board.debounce_len;
        rel = board.release_len;
        if (!clean && $urandom_range(0, 4) == 0) begin
            // arbitrary column noise
            repeat ($urandom_range(1, 8)) send_tick(4'($urandom_range(0, 15)));
            return;
        end
        held = '0;
        held[$urandom_range(0, 15)] = 1'b1;
        if (clean) begin
            press_len = deb + 8;
            quiet_len = rel + 2;
        end else begin
            if ($urandom_range(0, 4) == 0)
                held[$urandom_range(0, 15)] = 1'b1;   // two keys down
            press_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, deb + 5)
                                                    : deb + $urandom_range(6, 14);
            quiet_len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, rel)
                                                    : rel + $urandom_range(2, 6);
        end
        repeat (press_len) begin
            lines = ~held[board.row * 4 +: 4];
            if (!clean && $urandom_range(0, 15) == 0)
                lines = lines ^ (4'b0001 << $urandom_range(0, 3));  // contact bounce
            send_tick(lines);
        end
        repeat (quiet_len) send_tick(4'hF);
    endtask

    task automatic run_phase(input logic [15:0] deb, input logic [15:0] rel,
                             input int unsigned budget, input bit squeeze);
        int unsigned stop_at;
        settle();
        write_timing(deb, rel);
        stop_at = ticks_sent + budget;
        if (squeeze) begin
            // hold the sink off while the source keeps pushing
            fork
                begin
                    rx_blocked <= 1'b1;
                    repeat (PRESSURE_CYCLES) @(posedge aclk);
                    rx_blocked <= 1'b0;
                end
            join_none
        end
        while (ticks_sent < stop_at) begin
            pick_idling();
            key_episode(1'b0);
        end
    endtask

    initial begin
        int unsigned extra;
        board = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset timing values
        pick_idling();
        key_episode(1'b1);

        // directed walk with no debounce or hold-off
        settle();
        write_timing(16'd0, 16'd0);
        foreach (directed_cols[i])
            send_tick(directed_cols[i]);

        run_phase(16'd0, 16'd0, 40, 1'b0);
        run_phase(16'd1, 16'd0, 40, 1'b1);
        run_phase(16'd0, 16'd2, 40, 1'b0);
        run_phase(16'd3, 16'd5, 40, 1'b0);
        run_phase(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)), 40, 1'b0);

        // a few more phases if only a handful of keys have been reported
        extra = 0;
        while (board.keys_reported < 20 && extra < 2) begin
            run_phase(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)), 30, 1'b0);
            extra++;
        end

        // long waits: park on row 0 first, then one clean key, no idling
        tx_idle = 1'b0;
        while (!(board.phase == SCANNING && board.row == 0))
            send_tick(4'hF);
        settle();
        write_timing(16'd40, 16'd40);
        rx_idle <= 1'b0;
        key_episode(1'b1);

        run_phase(16'd2, 16'd1, 30, 1'b0);
        settle();

        if (board.errors == 0)
            $display("PASS matrix_keypad_scanner");
        else
            $display("FAIL matrix_keypad_scanner");
        $finish;
    end

endmodule
